// ----- hdl/hpe_pkg.sv -----
// Shared definitions for the hex-prefix encoder: error codes, word kinds
// and the default path depth. No dependencies.
package hpe_pkg;

	localparam int MAX_NIBBLES_DEF = 64;

	localparam logic [1:0] ERR_NONE       = 2'd0;
	localparam logic [1:0] ERR_OVERFLOW   = 2'd1;
	localparam logic [1:0] ERR_EARLY_TERM = 2'd2;

	// What the read stage hands to the output stage.
	typedef enum logic [1:0] {
		KIND_HDR,
		KIND_PAIR,
		KIND_ERR
	} kind_t;

	typedef struct packed {
		logic       valid;
		kind_t      kind;
		logic       last;
		logic [1:0] err;
		logic       term;
		logic       odd;
	} rd_ctl_t;

endpackage

// ----- hdl/hpe_nib_ram.sv -----
// Nibble buffer of the hex-prefix encoder: one write port and two read
// ports with registered read data. Depends on nothing.
module hpe_nib_ram #(
	parameter int DEPTH = 64,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [3:0]    wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr0,
	input  logic [AW-1:0] raddr1,
	output logic [3:0]    rdata0,
	output logic [3:0]    rdata1
);

	logic [3:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read data holds while no read is issued, so a stalled word keeps it.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata0 <= mem[raddr0];
			rdata1 <= mem[raddr1];
		end
	end

endmodule

// ----- hdl/hex_prefix_encoder_core.sv -----
// Top level of the hex-prefix (compact) encoder for trie key paths.
// Depends on hpe_pkg and hpe_nib_ram.
//
//   channel  | direction | handshake          | payload
//   ---------+-----------+--------------------+----------------------------------
//   input    | in        | in_valid/in_stall  | nibble, has_nibble, last
//   output   | out       | out_valid/out_stall| out_byte, out_last, error_code
//
// Input words are accepted while the block is loading a path. The word
// marked last starts emission, during which in_stall is high: the header and
// the packed bytes leave one per cycle while out_stall is low, n/2+1 bytes
// for n stored nibbles, or one error word. Emission rate is set by the two-port
// read of the nibble buffer feeding a one-word output register. Reset (arst_n,
// asynchronous) empties the path; the buffer itself is never cleared, since
// it is only used below the nibble count. A stall on the output holds the
// output register and then the read stage; emission resumes when the stall drops.
module hex_prefix_encoder_core #(
	parameter int MAX_NIBBLES = hpe_pkg::MAX_NIBBLES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [4:0] nibble,
	input  logic       has_nibble,
	input  logic       last,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic       out_last,
	output logic [1:0] error_code
);

	import hpe_pkg::*;

	localparam int AW = (MAX_NIBBLES > 1) ? $clog2(MAX_NIBBLES) : 1;
	localparam int CW = $clog2(MAX_NIBBLES + 1);
	localparam int BW = $clog2(MAX_NIBBLES / 2 + 2);

	typedef enum logic {
		ST_LOAD,
		ST_EMIT
	} state_t;

	state_t        state_q;
	logic [CW-1:0] count_q;
	logic [1:0]    err_q;
	logic          term_q;
	logic          odd_q;
	logic          hdr_pending_q;
	logic [AW-1:0] addr_q;
	logic [BW-1:0] bytes_left_q;
	rd_ctl_t       ctl_s1;
	logic          out_valid_q;
	logic [7:0]    out_byte_q;
	logic          out_last_q;
	logic [1:0]    out_err_q;

	// Load side.
	logic          in_acc;
	logic          nib_write;
	logic          nib_term;
	logic [1:0]    err_next;
	logic [CW-1:0] count_next;

	// Emission side.
	logic          out_free;
	logic          s1_adv;
	logic          issue;
	logic          issue_last;
	logic [AW-1:0] raddr0;
	logic [AW-1:0] raddr1;
	logic [3:0]    rdata0;
	logic [3:0]    rdata1;
	logic [7:0]    byte_s1;

	assign in_stall = (state_q != ST_LOAD);
	assign in_acc   = in_valid && !in_stall;

	always_comb begin
		nib_write  = 1'b0;
		nib_term   = 1'b0;
		err_next   = err_q;
		count_next = count_q;
		if (has_nibble && err_q == ERR_NONE) begin
			if (nibble[4]) begin
				if (last) begin
					nib_term = 1'b1;
				end else begin
					err_next = ERR_EARLY_TERM;
				end
			end else if (count_q < CW'(MAX_NIBBLES)) begin
				nib_write  = 1'b1;
				count_next = count_q + CW'(1);
			end else begin
				err_next = ERR_OVERFLOW;
			end
		end
	end

	// The output register frees when empty or when its word is taken; the read
	// stage moves into it then, and a new read issues only behind a moving or
	// empty read stage so that registered read data is never overwritten.
	assign out_free   = !out_valid_q || !out_stall;
	assign s1_adv     = ctl_s1.valid && out_free;
	assign issue      = (state_q == ST_EMIT) && (!ctl_s1.valid || s1_adv);
	assign issue_last = (err_q != ERR_NONE) || (bytes_left_q == BW'(1));
	assign raddr0     = hdr_pending_q ? '0 : addr_q;
	assign raddr1     = addr_q + AW'(1);

	hpe_nib_ram #(
		.DEPTH (MAX_NIBBLES),
		.AW    (AW)
	) u_ram (
		.clk    (clk),
		.we     (in_acc && nib_write),
		.waddr  (count_q[AW-1:0]),
		.wdata  (nibble[3:0]),
		.re     (issue),
		.raddr0 (raddr0),
		.raddr1 (raddr1),
		.rdata0 (rdata0),
		.rdata1 (rdata1)
	);

	always_comb begin
		case (ctl_s1.kind)
			KIND_HDR:  byte_s1 = {2'b00, ctl_s1.term, ctl_s1.odd,
				ctl_s1.odd ? rdata0 : 4'h0};
			KIND_PAIR: byte_s1 = {rdata0, rdata1};
			KIND_ERR:  byte_s1 = 8'h00;
			default:   byte_s1 = 8'h00;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_LOAD;
			count_q       <= '0;
			err_q         <= ERR_NONE;
			term_q        <= 1'b0;
			odd_q         <= 1'b0;
			hdr_pending_q <= 1'b0;
			addr_q        <= '0;
			bytes_left_q  <= '0;
			ctl_s1        <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (in_acc) begin
				count_q <= count_next;
				err_q   <= err_next;
				if (last) begin
					state_q       <= ST_EMIT;
					term_q        <= nib_term;
					odd_q         <= count_next[0];
					hdr_pending_q <= 1'b1;
					addr_q        <= AW'(count_next[0]);
					bytes_left_q  <= BW'(count_next >> 1) + BW'(1);
				end
			end

			if (issue) begin
				ctl_s1.valid <= 1'b1;
				ctl_s1.last  <= issue_last;
				ctl_s1.err   <= err_q;
				ctl_s1.term  <= term_q;
				ctl_s1.odd   <= odd_q;
				if (err_q != ERR_NONE) begin
					ctl_s1.kind <= KIND_ERR;
				end else if (hdr_pending_q) begin
					ctl_s1.kind <= KIND_HDR;
				end else begin
					ctl_s1.kind <= KIND_PAIR;
				end
				if (!hdr_pending_q) begin
					addr_q <= addr_q + AW'(2);
				end
				hdr_pending_q <= 1'b0;
				bytes_left_q  <= bytes_left_q - BW'(1);
				if (issue_last) begin
					state_q <= ST_LOAD;
					count_q <= '0;
					err_q   <= ERR_NONE;
				end
			end else if (s1_adv) begin
				ctl_s1.valid <= 1'b0;
			end

			if (s1_adv) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			out_byte_q <= byte_s1;
			out_last_q <= ctl_s1.last;
			out_err_q  <= ctl_s1.err;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_byte   = out_byte_q;
	assign out_last   = out_last_q;
	assign error_code = out_err_q;

	// An error word is always the only word of its path.
	a_err_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && error_code != ERR_NONE |-> out_last && out_byte == 8'h00)
		else $error("error word without out_last or with a nonzero byte");

	// The word that closes a path puts the block into emission.
	a_last_starts_emit: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && last |=> in_stall)
		else $error("input not held off after the closing word");

	// The nibble count never passes the buffer depth.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_NIBBLES))
		else $error("nibble count beyond buffer depth");

	// A stalled read stage issues no new read over its held data.
	a_no_read_over_held: assert property (@(posedge clk) disable iff (!arst_n)
		ctl_s1.valid && !s1_adv |-> !issue)
		else $error("read issued while the read stage is held");

endmodule
